@@ sv/slx_pkg.sv @@
// slx_pkg: shared types, token kind codes, character classes and keyword table
// for the script lexer; no dependencies
package slx_pkg;

  // default sizes handed to the top level
  localparam int POS_WIDTH_DEF   = 16;
  localparam int KEYWORD_MAX_DEF = 9;

  // result queue depth, a power of two
  localparam int OUT_DEPTH = 4;

  localparam int KIND_W = 6;
  localparam int FLD_W  = 16;

  // token kinds
  localparam logic [KIND_W-1:0] K_END     = 6'd0;
  localparam logic [KIND_W-1:0] K_ERR     = 6'd1;
  localparam logic [KIND_W-1:0] K_NUM     = 6'd2;
  localparam logic [KIND_W-1:0] K_STR     = 6'd3;
  localparam logic [KIND_W-1:0] K_IDENT   = 6'd4;
  localparam int                K_KW_BASE = 5;
  localparam logic [KIND_W-1:0] K_NONE    = 6'd0;  // no operator matched
  localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd21;
  localparam logic [KIND_W-1:0] K_PLUS    = 6'd22;
  localparam logic [KIND_W-1:0] K_MINUS   = 6'd23;
  localparam logic [KIND_W-1:0] K_STAR    = 6'd24;
  localparam logic [KIND_W-1:0] K_SLASH   = 6'd25;
  localparam logic [KIND_W-1:0] K_PCT     = 6'd26;
  localparam logic [KIND_W-1:0] K_EQ      = 6'd27;
  localparam logic [KIND_W-1:0] K_NE      = 6'd28;
  localparam logic [KIND_W-1:0] K_LT      = 6'd29;
  localparam logic [KIND_W-1:0] K_GT      = 6'd30;
  localparam logic [KIND_W-1:0] K_LE      = 6'd31;
  localparam logic [KIND_W-1:0] K_GE      = 6'd32;
  localparam logic [KIND_W-1:0] K_COMMA   = 6'd33;
  localparam logic [KIND_W-1:0] K_COLON   = 6'd34;
  localparam logic [KIND_W-1:0] K_SEMI    = 6'd35;
  localparam logic [KIND_W-1:0] K_LPAREN  = 6'd36;
  localparam logic [KIND_W-1:0] K_RPAREN  = 6'd37;
  localparam logic [KIND_W-1:0] K_LBRACE  = 6'd38;
  localparam logic [KIND_W-1:0] K_RBRACE  = 6'd39;
  localparam logic [KIND_W-1:0] K_LBRACK  = 6'd40;
  localparam logic [KIND_W-1:0] K_RBRACK  = 6'd41;

  // characters with a special role
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;

  // keyword table, text right-justified (last character in the low byte)
  localparam int NUM_KW      = 16;
  localparam int KW_TEXT_MAX = 9;
  localparam logic [8*KW_TEXT_MAX-1:0] KW_TEXT [NUM_KW] = '{
    "null", "true", "false", "function", "return", "var", "for", "break",
    "continue", "if", "elif", "else", "print", "printLine", "and", "or"
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd4, 4'd4, 4'd5, 4'd8, 4'd6, 4'd3, 4'd3, 4'd5,
    4'd8, 4'd2, 4'd4, 4'd4, 4'd5, 4'd9, 4'd3, 4'd2
  };

  // one result beat
  typedef struct packed {
    logic              last;
    logic [FLD_W-1:0]  tok_len;
    logic [FLD_W-1:0]  start_pos;
    logic [KIND_W-1:0] kind;
  } slx_tok_t;

  function automatic slx_tok_t mk_tok(input logic [KIND_W-1:0] kind,
                                      input logic [FLD_W-1:0] start_pos,
                                      input logic [FLD_W-1:0] tok_len,
                                      input logic last);
    slx_tok_t t;
    t.kind      = kind;
    t.start_pos = start_pos;
    t.tok_len   = tok_len;
    t.last      = last;
    return t;
  endfunction

  // character i of keyword k, counted from the first character
  function automatic logic [7:0] kw_char(input int k, input int i);
    logic [8*KW_TEXT_MAX-1:0] t;
    int l;
    t = KW_TEXT[k];
    l = int'(KW_LEN[k]);
    if (i < l) return t[8*(l-1-i) +: 8];
    else return 8'h00;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64)) ||
           ((c >= 8'd91) && (c <= 8'd96)) || ((c >= 8'd123) && (c <= 8'd126));
  endfunction

  function automatic logic is_print(input logic [7:0] c);
    return (c >= 8'd32) && (c <= 8'd126);
  endfunction

  function automatic logic [KIND_W-1:0] single_op(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      8'h3d:   k = K_ASSIGN;
      8'h2b:   k = K_PLUS;
      8'h2d:   k = K_MINUS;
      8'h2a:   k = K_STAR;
      8'h2f:   k = K_SLASH;
      8'h25:   k = K_PCT;
      8'h3c:   k = K_LT;
      8'h3e:   k = K_GT;
      8'h2c:   k = K_COMMA;
      8'h3a:   k = K_COLON;
      8'h3b:   k = K_SEMI;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7b:   k = K_LBRACE;
      8'h7d:   k = K_RBRACE;
      8'h5b:   k = K_LBRACK;
      8'h5d:   k = K_RBRACK;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] double_op(input logic [7:0] a,
                                                  input logic [7:0] b);
    logic [KIND_W-1:0] k;
    k = K_NONE;
    if (b == CH_EQ) begin
      case (a)
        CH_EQ:   k = K_EQ;
        CH_BANG: k = K_NE;
        CH_LT:   k = K_LE;
        CH_GT:   k = K_GE;
        default: k = K_NONE;
      endcase
    end
    return k;
  endfunction

endpackage

@@ sv/script_lexer_unit.sv @@
// script_lexer_unit: streaming maximal-munch scanner, one character in per beat,
// tokens out as kind / start / length; depends on slx_pkg
//
// usage
// - in channel: one ascii character per beat in in_tdata[7:0]; a zero character
//   ends the text, after which position restarts at zero for the next text
// - out channel: one token per beat; out_tdata holds kind, start position and
//   length, out_tlast marks the end-of-text or error-ending token
// - path: an accepted character lands in the input register, is scanned from
//   there and its tokens are written into the result queue, from which they
//   are offered on the out channel
// - throughput: one character per cycle; a character gives at most two tokens
//   and these go into a four-entry result queue drained one token per cycle,
//   so in_tready only drops when the queue cannot take two more tokens
// - receiver stall: the queue fills, then the input register holds and
//   in_tready falls; nothing is lost or repeated
// - reset: scanner idle, position zero, queue and input register empty
// - after an error token the block swallows characters silently up to the
//   next zero character
module script_lexer_unit #(
  parameter int POS_WIDTH   = slx_pkg::POS_WIDTH_DEF,
  parameter int KEYWORD_MAX = slx_pkg::KEYWORD_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // character beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  // token beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [5:0] kind, [21:6] start_pos, [37:22] tok_len
  output logic        out_tlast   // is_last
);

  // scanner modes
  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_INT  = 3'd1;
  localparam logic [2:0] M_FRAC = 3'd2;
  localparam logic [2:0] M_STR  = 3'd3;
  localparam logic [2:0] M_WORD = 3'd4;
  localparam logic [2:0] M_OP   = 3'd5;
  localparam logic [2:0] M_HALT = 3'd6;

  localparam int DEPTH = slx_pkg::OUT_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

  // input register
  logic       iv_r;
  logic [7:0] ich_r;
  logic       adv;

  // scanner state
  logic [2:0]           mode_r, mode_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] ts_r, ts_nxt;
  logic [7:0]           pend_r, pend_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [7:0]           wbuf_r [KEYWORD_MAX];
  logic [KEYWORD_MAX-1:0] wb_we;

  // result queue
  slx_pkg::slx_tok_t fifo_r [DEPTH];
  logic [PTR_W-1:0]  wp_r, rp_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              pop;

  // per-character results: first from closing the open token, second from
  // the character itself
  slx_pkg::slx_tok_t tok_a, tok_b, push0, push1;
  logic              tok_a_v, tok_b_v;
  logic [1:0]        n_push;
  logic              fall;

  logic [POS_WIDTH-1:0]  pos_inc, wlen;
  logic [POS_WIDTH+15:0] pos_ext, wlen_ext, slen_ext;
  logic [15:0]           pos16, wlen16, slen16, ts16;
  logic [POS_WIDTH+15:0] ts_ext;
  logic [5:0]            word_kind, k_dbl, k_sgl_pend, k_sgl_ch;
  logic                  kw_hit;

  assign adv       = iv_r && (cnt_r <= CNT_W'(DEPTH - 2));
  assign in_tready = !iv_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_tready) begin
      iv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ich_r <= in_tdata;
    end
  end

  // positions folded onto the 16-bit output fields
  assign pos_inc  = pos_r + POS_WIDTH'(1);
  assign wlen     = pos_r - ts_r;
  assign pos_ext  = {16'b0, pos_r};
  assign ts_ext   = {16'b0, ts_r};
  assign wlen_ext = {16'b0, wlen};
  assign slen_ext = {16'b0, wlen - POS_WIDTH'(1)};
  assign pos16    = pos_ext[15:0];
  assign ts16     = ts_ext[15:0];
  assign wlen16   = wlen_ext[15:0];
  assign slen16   = slen_ext[15:0];

  assign k_dbl      = slx_pkg::double_op(pend_r, ich_r);
  assign k_sgl_pend = slx_pkg::single_op(pend_r);
  assign k_sgl_ch   = slx_pkg::single_op(ich_r);

  // keyword lookup over the buffered word
  always_comb begin
    word_kind = slx_pkg::K_IDENT;
    kw_hit    = 1'b0;
    for (int k = 0; k < slx_pkg::NUM_KW; k++) begin
      kw_hit = (wlen == POS_WIDTH'(slx_pkg::KW_LEN[k]));
      for (int i = 0; i < slx_pkg::KW_TEXT_MAX; i++) begin
        if (i < int'(slx_pkg::KW_LEN[k])) begin
          kw_hit = kw_hit && (wbuf_r[i] == slx_pkg::kw_char(k, i));
        end
      end
      if (kw_hit && !ovf_r) begin
        word_kind = 6'(slx_pkg::K_KW_BASE + k);
      end
    end
  end

  // scanner step
  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    ts_nxt   = ts_r;
    pend_nxt = pend_r;
    ovf_nxt  = ovf_r;
    wb_we    = '0;
    tok_a    = '0;
    tok_b    = '0;
    tok_a_v  = 1'b0;
    tok_b_v  = 1'b0;
    fall     = 1'b0;

    if (mode_r == M_HALT) begin
      if (ich_r == slx_pkg::CH_NUL) begin
        mode_nxt = M_IDLE;
        pos_nxt  = '0;
        ts_nxt   = '0;
      end
    end else if (ich_r != slx_pkg::CH_NUL && pos_r == POS_MAX) begin
      // position overflow drops any open token
      tok_a_v  = 1'b1;
      tok_a    = slx_pkg::mk_tok(slx_pkg::K_ERR, pos16, 16'd0, 1'b1);
      mode_nxt = M_HALT;
    end else begin
      case (mode_r)
        M_INT: begin
          if (slx_pkg::is_digit(ich_r)) begin
            pos_nxt = pos_inc;
          end else if (ich_r == slx_pkg::CH_DOT) begin
            mode_nxt = M_FRAC;
            pos_nxt  = pos_inc;
          end else begin
            tok_a_v = 1'b1;
            tok_a   = slx_pkg::mk_tok(slx_pkg::K_NUM, ts16, wlen16, 1'b0);
            fall    = 1'b1;
          end
        end
        M_FRAC: begin
          if (slx_pkg::is_digit(ich_r)) begin
            pos_nxt = pos_inc;
          end else begin
            tok_a_v = 1'b1;
            tok_a   = slx_pkg::mk_tok(slx_pkg::K_NUM, ts16, wlen16, 1'b0);
            fall    = 1'b1;
          end
        end
        M_WORD: begin
          if (slx_pkg::is_digit(ich_r) || slx_pkg::is_alpha(ich_r)) begin
            if (wlen < POS_WIDTH'(KEYWORD_MAX)) begin
              for (int j = 0; j < KEYWORD_MAX; j++) begin
                wb_we[j] = (wlen == POS_WIDTH'(j));
              end
            end else begin
              ovf_nxt = 1'b1;
            end
            pos_nxt = pos_inc;
          end else begin
            tok_a_v = 1'b1;
            tok_a   = slx_pkg::mk_tok(word_kind, ts16, wlen16, 1'b0);
            fall    = 1'b1;
          end
        end
        M_STR: begin
          if (ich_r == slx_pkg::CH_QUOTE) begin
            tok_a_v  = 1'b1;
            tok_a    = slx_pkg::mk_tok(slx_pkg::K_STR, ts16, slen16, 1'b0);
            mode_nxt = M_IDLE;
            pos_nxt  = pos_inc;
          end else if (slx_pkg::is_print(ich_r)) begin
            pos_nxt = pos_inc;
          end else begin
            // unclosed string, reported at the opening quote
            tok_a_v  = 1'b1;
            tok_a    = slx_pkg::mk_tok(slx_pkg::K_ERR, ts16, 16'd0, 1'b1);
            mode_nxt = M_HALT;
          end
        end
        M_OP: begin
          if (k_dbl != slx_pkg::K_NONE) begin
            tok_a_v  = 1'b1;
            tok_a    = slx_pkg::mk_tok(k_dbl, ts16, 16'd2, 1'b0);
            mode_nxt = M_IDLE;
            pos_nxt  = pos_inc;
          end else if (k_sgl_pend == slx_pkg::K_NONE) begin
            tok_a_v  = 1'b1;
            tok_a    = slx_pkg::mk_tok(slx_pkg::K_ERR, ts16, 16'd0, 1'b1);
            mode_nxt = M_HALT;
          end else begin
            tok_a_v = 1'b1;
            tok_a   = slx_pkg::mk_tok(k_sgl_pend, ts16, 16'd1, 1'b0);
            fall    = 1'b1;
          end
        end
        default: begin
          fall = 1'b1;
        end
      endcase

      // the character opens something new
      if (fall) begin
        mode_nxt = M_IDLE;
        if (ich_r == slx_pkg::CH_NUL) begin
          tok_b_v = 1'b1;
          tok_b   = slx_pkg::mk_tok(slx_pkg::K_END, pos16, 16'd0, 1'b1);
          pos_nxt = '0;
          ts_nxt  = '0;
        end else begin
          ts_nxt  = pos_r;
          pos_nxt = pos_inc;
          if (slx_pkg::is_digit(ich_r)) begin
            mode_nxt = M_INT;
          end else if (ich_r == slx_pkg::CH_QUOTE) begin
            mode_nxt = M_STR;
          end else if (slx_pkg::is_alpha(ich_r)) begin
            mode_nxt = M_WORD;
            wb_we[0] = 1'b1;
            ovf_nxt  = 1'b0;
          end else if (slx_pkg::is_punct(ich_r)) begin
            if (ich_r == slx_pkg::CH_EQ || ich_r == slx_pkg::CH_BANG ||
                ich_r == slx_pkg::CH_LT || ich_r == slx_pkg::CH_GT) begin
              pend_nxt = ich_r;
              mode_nxt = M_OP;
            end else if (k_sgl_ch == slx_pkg::K_NONE) begin
              tok_b_v  = 1'b1;
              tok_b    = slx_pkg::mk_tok(slx_pkg::K_ERR, pos16, 16'd0, 1'b1);
              mode_nxt = M_HALT;
              pos_nxt  = pos_r;
            end else begin
              tok_b_v = 1'b1;
              tok_b   = slx_pkg::mk_tok(k_sgl_ch, pos16, 16'd1, 1'b0);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= '0;
      ts_r   <= '0;
      pend_r <= '0;
      ovf_r  <= 1'b0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
      pend_r <= pend_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // word buffer, no reset: only entries of the current word are compared
  always_ff @(posedge clk) begin
    for (int j = 0; j < KEYWORD_MAX; j++) begin
      if (adv && wb_we[j]) begin
        wbuf_r[j] <= ich_r;
      end
    end
  end

  // result queue
  assign n_push = {1'b0, tok_a_v} + {1'b0, tok_b_v};
  assign push0  = tok_a_v ? tok_a : tok_b;
  assign push1  = tok_b;
  assign pop    = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (adv && n_push != 2'd0) begin
      fifo_r[wp_r] <= push0;
    end
    if (adv && n_push == 2'd2) begin
      fifo_r[wp_r + PTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (adv) begin
        wp_r <= wp_r + PTR_W'(n_push);
      end
      if (pop) begin
        rp_r <= rp_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + (adv ? CNT_W'(n_push) : CNT_W'(0)) - CNT_W'(pop);
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {2'b00, fifo_r[rp_r].tok_len, fifo_r[rp_r].start_pos,
                       fifo_r[rp_r].kind};
  assign out_tlast  = fifo_r[rp_r].last;

`ifndef SYNTHESIS
  // the queue never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("result queue overfilled");

  // a halted scanner emits nothing
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mode_r == M_HALT) |-> (n_push == 2'd0))
    else $error("token emitted while halted");

  // a zero character either restarts position for the next text or, inside an
  // open string or a lone bang, halts the scanner on an error
  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ich_r == slx_pkg::CH_NUL) |=>
      (mode_r == M_HALT || (pos_r == '0 && mode_r == M_IDLE)))
    else $error("end of text did not restart the scanner");
`endif

endmodule

@@ dv/script_lexer_unit_tb.sv @@
// script_lexer_unit_tb: self-checking bench for the streaming script scanner; drives
// character beats, predicts token beats with its own scanner model and compares
// them field by field; depends on slx_pkg and script_lexer_unit
`timescale 1ns / 100ps

module script_lexer_unit_tb;

  localparam int          KW_MAX      = 9;
  localparam logic [15:0] POS_LAST    = 16'hffff;
  localparam int          STALL_LIMIT = 2000;  // cycles with no beat on either side
  localparam int          HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int          ITEM_TARGET = 1100;  // character beats in the whole run
  localparam int          CALM_ITEMS  = 150;   // tail of the run without idling

  // scanner states of the predictor
  typedef enum logic [2:0] {
    SC_IDLE, SC_INT, SC_FRAC, SC_STR, SC_WORD, SC_OP, SC_HALT
  } scan_st_e;

  // one row of the directed table: character, and where obvious the expected token
  typedef struct packed {
    logic [7:0]        ch;
    logic              typed;
    logic [1:0]        n_tok;
    slx_pkg::slx_tok_t tok;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // empty text straight after reset
    '{slx_pkg::CH_NUL,   1'b1, 2'd1, '{1'b1, 16'd0, 16'd0, slx_pkg::K_END}},
    // string left open at end of text, then a swallowed character
    '{slx_pkg::CH_QUOTE, 1'b1, 2'd0, '0},
    '{"a",               1'b1, 2'd0, '0},
    '{slx_pkg::CH_NUL,   1'b1, 2'd1, '{1'b1, 16'd0, 16'd0, slx_pkg::K_ERR}},
    '{"x",               1'b1, 2'd0, '0},
    '{slx_pkg::CH_NUL,   1'b1, 2'd0, '0},
    // character that starts no operator
    '{"#",               1'b1, 2'd1, '{1'b1, 16'd0, 16'd0, slx_pkg::K_ERR}},
    '{slx_pkg::CH_NUL,   1'b1, 2'd0, '0},
    // bang not followed by equals
    '{slx_pkg::CH_BANG,  1'b1, 2'd0, '0},
    '{"a",               1'b1, 2'd1, '{1'b1, 16'd0, 16'd0, slx_pkg::K_ERR}},
    '{slx_pkg::CH_NUL,   1'b1, 2'd0, '0},
    // 1.0<= <ff> if ' ' > then end with a pending operator
    '{"1",               1'b0, 2'd0, '0},
    '{slx_pkg::CH_DOT,   1'b0, 2'd0, '0},
    '{"0",               1'b0, 2'd0, '0},
    '{slx_pkg::CH_LT,    1'b0, 2'd0, '0},
    '{slx_pkg::CH_EQ,    1'b0, 2'd0, '0},
    '{8'hff,             1'b0, 2'd0, '0},
    '{"i",               1'b0, 2'd0, '0},
    '{"f",               1'b0, 2'd0, '0},
    '{slx_pkg::CH_QUOTE, 1'b0, 2'd0, '0},
    '{" ",               1'b0, 2'd0, '0},
    '{slx_pkg::CH_QUOTE, 1'b0, 2'd0, '0},
    '{slx_pkg::CH_GT,    1'b0, 2'd0, '0},
    '{slx_pkg::CH_NUL,   1'b0, 2'd0, '0}
  };

  string kw_words [16] = '{
    "null", "true", "false", "function", "return", "var", "for", "break",
    "continue", "if", "elif", "else", "print", "printLine", "and", "or"
  };
  string op_txt [21] = '{
    "=", "+", "-", "*", "/", "%", "==", "!=", "<", ">", "<=", ">=",
    ",", ":", ";", "(", ")", "{", "}", "[", "]"
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  // predictor state
  scan_st_e    sc_st      = SC_IDLE;
  logic [15:0] sc_pos     = '0;
  logic [15:0] sc_tstart  = '0;
  logic [7:0]  sc_word [KW_MAX];
  logic        sc_wovf    = 1'b0;
  logic [7:0]  sc_pend    = '0;
  slx_pkg::slx_tok_t scan_out [2];
  int          scan_n;

  slx_pkg::slx_tok_t tok_q [$];  // tokens still owed by the block

  bit calm     = 1'b0;     // no idling on either side
  bit hold_req = 1'b0;
  bit held     = 1'b0;
  int fail_cnt = 0;
  int tok_seen = 0;
  int chars_in = 0;
  int texts    = 0;
  int err_texts = 0;
  int idle_cyc = 0;
  int hold_cnt;

  script_lexer_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  function automatic bit is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alf(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // printable non-alphanumeric, non-space characters
  function automatic bit is_pun(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic logic [5:0] lone_kind(input logic [7:0] c);
    case (c)
      "=":     return slx_pkg::K_ASSIGN;
      "+":     return slx_pkg::K_PLUS;
      "-":     return slx_pkg::K_MINUS;
      "*":     return slx_pkg::K_STAR;
      "/":     return slx_pkg::K_SLASH;
      "%":     return slx_pkg::K_PCT;
      "<":     return slx_pkg::K_LT;
      ">":     return slx_pkg::K_GT;
      ",":     return slx_pkg::K_COMMA;
      ":":     return slx_pkg::K_COLON;
      ";":     return slx_pkg::K_SEMI;
      "(":     return slx_pkg::K_LPAREN;
      ")":     return slx_pkg::K_RPAREN;
      "{":     return slx_pkg::K_LBRACE;
      "}":     return slx_pkg::K_RBRACE;
      "[":     return slx_pkg::K_LBRACK;
      "]":     return slx_pkg::K_RBRACK;
      default: return slx_pkg::K_NONE;
    endcase
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    if (b != "=") return slx_pkg::K_NONE;
    case (a)
      "=":     return slx_pkg::K_EQ;
      "!":     return slx_pkg::K_NE;
      "<":     return slx_pkg::K_LE;
      ">":     return slx_pkg::K_GE;
      default: return slx_pkg::K_NONE;
    endcase
  endfunction

  // keyword lookup on the buffered word
  function automatic logic [5:0] word_kind(input logic [15:0] len);
    bit hit;
    if (sc_wovf || len > KW_MAX) return slx_pkg::K_IDENT;
    for (int i = 0; i < 16; i++) begin
      if (kw_words[i].len() == len) begin
        hit = 1'b1;
        for (int j = 0; j < len; j++)
          if (kw_words[i][j] != sc_word[j]) hit = 1'b0;
        if (hit) return 6'(slx_pkg::K_KW_BASE + i);
      end
    end
    return slx_pkg::K_IDENT;
  endfunction

  function automatic void emit(input logic [5:0] kind, input logic [15:0] start,
                               input logic [15:0] len, input logic last);
    scan_out[scan_n] = '{last, len, start, kind};
    scan_n++;
    if (kind == slx_pkg::K_ERR) err_texts++;
  endfunction

  // advances the predictor by one character, leaving its tokens in scan_out
  task automatic scan_char(input logic [7:0] c);
    logic [5:0]  k;
    logic [15:0] run;
    scan_n = 0;
    run = sc_pos - sc_tstart;
    if (sc_st == SC_HALT) begin
      if (c == slx_pkg::CH_NUL) begin
        sc_st = SC_IDLE;
        sc_pos = '0;
        sc_tstart = '0;
      end
      return;
    end
    // position counter at its top: any open token is dropped
    if (c != slx_pkg::CH_NUL && sc_pos == POS_LAST) begin
      emit(slx_pkg::K_ERR, sc_pos, 16'd0, 1'b1);
      sc_st = SC_HALT;
      return;
    end
    case (sc_st)
      SC_INT: begin
        if (is_dig(c)) begin
          sc_pos++;
          return;
        end
        if (c == slx_pkg::CH_DOT) begin
          sc_st = SC_FRAC;
          sc_pos++;
          return;
        end
        emit(slx_pkg::K_NUM, sc_tstart, run, 1'b0);
      end
      SC_FRAC: begin
        if (is_dig(c)) begin
          sc_pos++;
          return;
        end
        emit(slx_pkg::K_NUM, sc_tstart, run, 1'b0);
      end
      SC_WORD: begin
        if (is_dig(c) || is_alf(c)) begin
          if (run < KW_MAX) sc_word[run] = c;
          else sc_wovf = 1'b1;
          sc_pos++;
          return;
        end
        emit(word_kind(run), sc_tstart, run, 1'b0);
      end
      SC_STR: begin
        if (c == slx_pkg::CH_QUOTE) begin
          emit(slx_pkg::K_STR, sc_tstart, run - 16'd1, 1'b0);
          sc_st = SC_IDLE;
          sc_pos++;
          return;
        end
        if (c >= 8'd32 && c <= 8'd126) begin
          sc_pos++;
          return;
        end
        // unclosed string: error points at the opening quote
        emit(slx_pkg::K_ERR, sc_tstart, 16'd0, 1'b1);
        sc_st = SC_HALT;
        return;
      end
      SC_OP: begin
        k = pair_kind(sc_pend, c);
        if (k != slx_pkg::K_NONE) begin
          emit(k, sc_tstart, 16'd2, 1'b0);
          sc_st = SC_IDLE;
          sc_pos++;
          return;
        end
        k = lone_kind(sc_pend);
        if (k == slx_pkg::K_NONE) begin
          emit(slx_pkg::K_ERR, sc_tstart, 16'd0, 1'b1);
          sc_st = SC_HALT;
          return;
        end
        emit(k, sc_tstart, 16'd1, 1'b0);
      end
      default: ;
    endcase
    sc_st = SC_IDLE;
    if (c == slx_pkg::CH_NUL) begin
      emit(slx_pkg::K_END, sc_pos, 16'd0, 1'b1);
      sc_pos = '0;
      sc_tstart = '0;
      return;
    end
    sc_tstart = sc_pos;
    if (is_dig(c)) begin
      sc_st = SC_INT;
    end else if (c == slx_pkg::CH_QUOTE) begin
      sc_st = SC_STR;
    end else if (is_alf(c)) begin
      sc_st = SC_WORD;
      sc_word[0] = c;
      sc_wovf = 1'b0;
    end else if (is_pun(c)) begin
      if (c == slx_pkg::CH_EQ || c == slx_pkg::CH_BANG || c == slx_pkg::CH_LT ||
          c == slx_pkg::CH_GT) begin
        sc_pend = c;
        sc_st = SC_OP;
      end else begin
        k = lone_kind(c);
        if (k == slx_pkg::K_NONE) begin
          emit(slx_pkg::K_ERR, sc_pos, 16'd0, 1'b1);
          sc_st = SC_HALT;
          return;
        end
        emit(k, sc_pos, 16'd1, 1'b0);
      end
    end
    sc_pos++;
  endtask

  // offers one character beat, waits for it to be taken, then books its tokens
  task automatic feed(input logic [7:0] c, input logic typed, input logic [1:0] n_tok,
                      input slx_pkg::slx_tok_t tok);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_in++;
    if (c == slx_pkg::CH_NUL) texts++;
    scan_char(c);
    if (typed) begin
      if (n_tok != 2'd0) tok_q.insert(tok_q.size(), tok);
    end else begin
      for (int i = 0; i < scan_n; i++) tok_q.insert(tok_q.size(), scan_out[i]);
    end
  endtask

  function automatic logic [7:0] pick_alpha();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] pick_alnum();
    return ($urandom_range(0, 3) == 0) ? 8'("0" + $urandom_range(0, 9)) : pick_alpha();
  endfunction

  // one random text: mostly well-formed tokens with random separators, a little
  // noise and the odd broken string, always closed by a zero character
  task automatic send_text();
    logic [7:0] txt [$];
    logic [7:0] c;
    string      w;
    int         n_tok, cat, len;
    n_tok = $urandom_range(1, 12);
    for (int t = 0; t < n_tok; t++) begin
      cat = $urandom_range(0, 23);
      if (cat < 4) begin
        // keyword, sometimes with a tail that turns it into an identifier
        w = kw_words[$urandom_range(0, 15)];
        for (int j = 0; j < w.len(); j++) txt.insert(txt.size(), w[j]);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) txt.insert(txt.size(), pick_alnum());
      end else if (cat < 8) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 8);
        txt.insert(txt.size(), pick_alpha());
        repeat (len - 1) txt.insert(txt.size(), pick_alnum());
      end else if (cat < 11) begin
        repeat ($urandom_range(1, 5)) txt.insert(txt.size(), 8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 0) begin
          txt.insert(txt.size(), slx_pkg::CH_DOT);
          repeat ($urandom_range(0, 3))
            txt.insert(txt.size(), 8'("0" + $urandom_range(0, 9)));
        end
      end else if (cat < 14) begin
        txt.insert(txt.size(), slx_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(32, 126));
          if (c == slx_pkg::CH_QUOTE) c = "~";
          txt.insert(txt.size(), c);
        end
        // broken string: control or high character in place of the closing quote
        if ($urandom_range(0, 14) == 0)
          txt.insert(txt.size(), ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 31))
                                                           : 8'($urandom_range(127, 255)));
        else if ($urandom_range(0, 19) != 0)
          txt.insert(txt.size(), slx_pkg::CH_QUOTE);
      end else if (cat < 19) begin
        w = op_txt[$urandom_range(0, 20)];
        for (int j = 0; j < w.len(); j++) txt.insert(txt.size(), w[j]);
      end else if (cat == 19) begin
        txt.insert(txt.size(), 8'($urandom_range(1, 255)));
      end
      case ($urandom_range(0, 7))
        0:       ;
        1:       txt.insert(txt.size(), 8'h09);
        2:       txt.insert(txt.size(), 8'h0d);
        3:       txt.insert(txt.size(), 8'h0a);
        default: txt.insert(txt.size(), " ");
      endcase
    end
    txt.insert(txt.size(), slx_pkg::CH_NUL);
    foreach (txt[i]) feed(txt[i], 1'b0, 2'd0, '0);
  endtask

  // token beat checker
  always @(posedge clk) begin : tok_check
    slx_pkg::slx_tok_t want;
    if (rst_n && out_tvalid && out_tready) begin
      tok_seen++;
      if (tok_q.size() == 0) begin
        $error("token beat with nothing owed: tdata %h tlast %b", out_tdata, out_tlast);
        fail_cnt++;
      end else begin
        want = tok_q.pop_front();
        if (out_tdata[5:0] !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tdata[5:0]);
          fail_cnt++;
        end
        if (out_tdata[21:6] !== want.start_pos) begin
          $error("start_pos: expected %0d, got %0d", want.start_pos, out_tdata[21:6]);
          fail_cnt++;
        end
        if (out_tdata[37:22] !== want.tok_len) begin
          $error("tok_len: expected %0d, got %0d", want.tok_len, out_tdata[37:22]);
          fail_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("is_last: expected %0d, got %0d", want.last, out_tlast);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
    if (idle_cyc >= STALL_LIMIT) begin
      $display("[script_lexer_unit] ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, quiet stretches, and one long hold-off
  initial begin : sink
    int r;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 9);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        hold_cnt = 1;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
      end else if (!calm && r < 2) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        if (!calm && r == 2) repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  initial begin : stim
    dir_row_t row;
    foreach (sc_word[i]) sc_word[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      feed(row.ch, row.typed, row.n_tok, row.tok);
    end

    // random texts; midway the receiver holds off so the block backs up
    while (chars_in < ITEM_TARGET - CALM_ITEMS) begin
      if (!held && chars_in > ITEM_TARGET / 2) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      send_text();
    end

    // last part without idling on either side
    calm = 1'b1;
    while (chars_in < ITEM_TARGET) send_text();
    in_tvalid <= 1'b0;

    while (tok_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("scanned %0d texts in %0d character beats, %0d token beats compared",
             texts, chars_in, tok_seen);
    $display("%0d texts ended by an error token, receiver held off once long enough to back up",
             err_texts);
    if (fail_cnt == 0) begin
      $display("[script_lexer_unit] OK");
    end else begin
      $display("[script_lexer_unit] ERROR");
    end
    $finish;
  end

endmodule
